### rtl/core/cbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types, constants and helpers of the chunked body decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

   // Default number of hex digits allowed in one size line.
   localparam int SIZE_DIGITS_DEF = 8;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   // Parser phases, one-hot.
   typedef enum logic [8:0] {
      PH_SIZE    = 9'b0_0000_0001,
      PH_SIZE_LF = 9'b0_0000_0010,
      PH_DATA    = 9'b0_0000_0100,
      PH_DATA_CR = 9'b0_0000_1000,
      PH_DATA_LF = 9'b0_0001_0000,
      PH_LAST_CR = 9'b0_0010_0000,
      PH_LAST_LF = 9'b0_0100_0000,
      PH_DONE    = 9'b0_1000_0000,
      PH_ERROR   = 9'b1_0000_0000
   } phase_type;

   // One result beat.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       body_done;
      logic       format_error;
   } rsp_beat_type;

   // Decoded hex digit.
   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type d;
      d.is_hex = 1'b1;
      d.value  = 4'h0;
      if (c inside {[8'h30:8'h39]}) begin
         d.value = c[3:0];
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         d.value = c[3:0] + 4'd9;
      end else begin
         d.is_hex = 1'b0;
      end
      return d;
   endfunction

endpackage
`default_nettype wire

### rtl/core/cbd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbd_parser
// Phase machine, size accumulator and payload down-counter of the decoder.
// ----------------------------------------------------------------------------
module cbd_parser #(
   parameter int SIZE_DIGITS = cbd_pkg::SIZE_DIGITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           in_byte,
   input  wire logic                 start_body,
   output cbd_pkg::rsp_beat_type     beat
);
   import cbd_pkg::*;

   localparam int BW = 4 * SIZE_DIGITS;
   localparam int CW = $clog2(SIZE_DIGITS + 1);

   phase_type       phase_ff, phase_in, phase_cur;
   logic [BW-1:0]   remain_ff, remain_in, remain_cur, remain_dec;
   logic [CW-1:0]   count_ff, count_in, count_cur;
   hex_digit_type   digit;

   always_comb begin
      // A start beat restarts the parser before the byte is looked at.
      phase_cur  = start_body ? PH_SIZE : phase_ff;
      remain_cur = start_body ? '0 : remain_ff;
      count_cur  = start_body ? '0 : count_ff;
      digit      = hex_decode(in_byte);
      remain_dec = remain_cur - BW'(1);

      phase_in  = phase_cur;
      remain_in = remain_cur;
      count_in  = count_cur;
      beat.out_byte  = 8'h00;
      beat.out_valid = 1'b0;

      case (phase_cur)
         PH_SIZE: begin
            if (digit.is_hex) begin
               if (count_cur >= CW'(SIZE_DIGITS)) begin
                  phase_in = PH_ERROR;
               end else begin
                  remain_in = (remain_cur << 4) | BW'(digit.value);
                  count_in  = count_cur + CW'(1);
               end
            end else if (in_byte == CH_CR && count_cur != '0) begin
               phase_in = PH_SIZE_LF;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_SIZE_LF: begin
            if (in_byte != CH_LF) begin
               phase_in = PH_ERROR;
            end else begin
               phase_in = (remain_cur == '0) ? PH_LAST_CR : PH_DATA;
            end
         end
         PH_DATA: begin
            beat.out_byte  = in_byte;
            beat.out_valid = 1'b1;
            remain_in      = remain_dec;
            if (remain_dec == '0) begin
               phase_in = PH_DATA_CR;
            end
         end
         PH_DATA_CR: begin
            phase_in = (in_byte == CH_CR) ? PH_DATA_LF : PH_ERROR;
         end
         PH_DATA_LF: begin
            if (in_byte == CH_LF) begin
               phase_in  = PH_SIZE;
               remain_in = '0;
               count_in  = '0;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_LAST_CR: begin
            phase_in = (in_byte == CH_CR) ? PH_LAST_LF : PH_ERROR;
         end
         PH_LAST_LF: begin
            phase_in = (in_byte == CH_LF) ? PH_DONE : PH_ERROR;
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase

      beat.body_done    = (phase_in == PH_DONE);
      beat.format_error = (phase_in == PH_ERROR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SIZE;
         remain_ff <= '0;
         count_ff  <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/cbd_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbd_out_reg
// Result register with a ready that lets a new beat in while the old one leaves.
// ----------------------------------------------------------------------------
module cbd_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire cbd_pkg::rsp_beat_type beat_in,
   output logic                      can_load,
   output logic                      beat_valid,
   input  wire logic                 beat_ready,
   output cbd_pkg::rsp_beat_type     beat_out
);
   import cbd_pkg::*;

   logic         valid_ff, valid_in;
   rsp_beat_type beat_ff;

   assign can_load   = !valid_ff || beat_ready;
   assign valid_in   = load || (valid_ff && !beat_ready);
   assign beat_valid = valid_ff;
   assign beat_out   = beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= beat_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/chunked_body_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chunked_body_decoder
// Decodes a chunked transfer-coded body, one encoded byte per beat.
// ----------------------------------------------------------------------------
// Usage: the req_ channel carries one raw body byte per beat; req_start_body
// marks the first byte of a new body and restarts the parser. Every accepted
// request beat yields exactly one rsp_ beat: the payload byte with
// rsp_out_valid when the byte is chunk data, plus the body_done and sticky
// format_error flags as they stand after that byte.
// Results are registered: the beat accepted at one edge appears on rsp_ after
// that edge. Throughput is one byte per cycle while rsp_ready keeps up; the
// phase machine and size/down-counter update in the cycle a byte is accepted.
// Stalls: the result register frees as soon as rsp_ready takes its beat, so
// req_ready stays high while the receiver keeps up. When rsp_ready is low
// with a beat pending, req_ready drops and the pending beat holds.
// Reset (synchronous, active high) empties the result register and puts the
// parser at the start of a size line, as if a body had been started.
// SIZE_DIGITS sets the longest size line and the width of the byte counter.
// ----------------------------------------------------------------------------
module chunked_body_decoder #(
   parameter int SIZE_DIGITS = cbd_pkg::SIZE_DIGITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_start_body,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_valid,
   output logic            rsp_body_done,
   output logic            rsp_format_error
);
   import cbd_pkg::*;

   logic         accept;
   rsp_beat_type next_beat;
   rsp_beat_type held_beat;

   // A request beat is taken whenever the result register can load.
   assign accept = req_valid && req_ready;

   cbd_parser #(
      .SIZE_DIGITS (SIZE_DIGITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_in_byte),
      .start_body (req_start_body),
      .beat       (next_beat)
   );

   cbd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .beat_in    (next_beat),
      .can_load   (req_ready),
      .beat_valid (rsp_valid),
      .beat_ready (rsp_ready),
      .beat_out   (held_beat)
   );

   assign rsp_out_byte     = held_beat.out_byte;
   assign rsp_out_valid    = held_beat.out_valid;
   assign rsp_body_done    = held_beat.body_done;
   assign rsp_format_error = held_beat.format_error;

`ifndef SYNTH
   // Done and error are exclusive end states.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_body_done && rsp_format_error))
      else $error("body_done and format_error both set");

   // Payload is only passed while the body is still being parsed cleanly.
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_valid) |-> (!rsp_body_done && !rsp_format_error))
      else $error("payload beat carries an end flag");

   // Every accepted byte produces a result beat in the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted byte produced no result beat");

   // An empty result register never blocks the input.
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");
`endif

endmodule
`default_nettype wire

### sim/tb_chunked_body_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chunked_body_decoder
// Self-checking bench for the chunked body decoder. Encoded bodies go in one
// byte per beat. An in-bench decoder predicts the beat that each byte causes,
// and every result beat is checked against it, field by field.
// ----------------------------------------------------------------------------
module tb_chunked_body_decoder;
   import cbd_pkg::*;

   localparam int SIZE_DIGITS  = cbd_pkg::SIZE_DIGITS_DEF;
   // The random part stops once this many bytes have reached the parser.
   // Bytes that land after body_done or format_error are not counted.
   localparam int PARSED_BEATS = 1400;
   localparam int CYCLE_LIMIT  = 400_000;

   // One byte on the request side, with its start-of-body mark.
   typedef struct {
      logic [7:0] b;
      logic       s;
   } body_byte_type;

   // Ways in which a generated body is broken on purpose.
   typedef enum int {
      FLAW_NONE,
      FLAW_SWAP,
      FLAW_DROP,
      FLAW_TRAILER,
      FLAW_RESTART,
      FLAW_CUT
   } flaw_kind_type;

   // -------------------------------------------------------------------------
   // Decoder prediction and result check.
   // -------------------------------------------------------------------------
   class chunk_decode_scoreboard;
      phase_type    phase;
      logic [63:0]  remaining;
      int           digits;
      rsp_beat_type decoded_beats[$];
      int parsed_beats;
      int payload_beats;
      int bodies_done;
      int bodies_bad;
      int checked;
      int mismatches;

      function new();
         restart_body();
      endfunction

      function void restart_body();
         phase     = PH_SIZE;
         remaining = '0;
         digits    = 0;
      endfunction

      function int nibble_value(input logic [7:0] c);
         if (c >= "0" && c <= "9") return int'(c) - int'("0");
         if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
         if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
         return -1;
      endfunction

      function int pending();
         return decoded_beats.size();
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         // Only the first few are printed; the rest are counted.
         if (mismatches <= 40) begin
            $display("[%0t] mismatch: %s", $realtime, what);
         end
      endtask

      // Runs one accepted byte through the decoder and queues the result.
      task note_byte(input logic [7:0] b, input logic s);
         rsp_beat_type r;
         phase_type    prev;
         int           d;
         if (s || (phase != PH_DONE && phase != PH_ERROR)) begin
            parsed_beats++;
         end
         if (s) begin
            restart_body();
         end
         prev = phase;
         r    = '0;
         case (phase)
            PH_SIZE: begin
               d = nibble_value(b);
               if (d >= 0) begin
                  if (digits >= SIZE_DIGITS) begin
                     phase = PH_ERROR;
                  end else begin
                     remaining = {remaining[59:0], d[3:0]};
                     digits++;
                  end
               end else if (b == CH_CR && digits != 0) begin
                  phase = PH_SIZE_LF;
               end else begin
                  phase = PH_ERROR;
               end
            end
            PH_SIZE_LF: begin
               if (b != CH_LF) begin
                  phase = PH_ERROR;
               end else if (remaining == 0) begin
                  phase = PH_LAST_CR;
               end else begin
                  phase = PH_DATA;
               end
            end
            PH_DATA: begin
               r.out_byte  = b;
               r.out_valid = 1'b1;
               payload_beats++;
               remaining = remaining - 64'd1;
               if (remaining == 0) begin
                  phase = PH_DATA_CR;
               end
            end
            PH_DATA_CR: begin
               if (b == CH_CR) begin
                  phase = PH_DATA_LF;
               end else begin
                  phase = PH_ERROR;
               end
            end
            PH_DATA_LF: begin
               if (b == CH_LF) begin
                  restart_body();
               end else begin
                  phase = PH_ERROR;
               end
            end
            PH_LAST_CR: begin
               if (b == CH_CR) begin
                  phase = PH_LAST_LF;
               end else begin
                  phase = PH_ERROR;
               end
            end
            PH_LAST_LF: begin
               if (b == CH_LF) begin
                  phase = PH_DONE;
               end else begin
                  phase = PH_ERROR;
               end
            end
            PH_DONE: begin
            end
            default: begin
               phase = PH_ERROR;
            end
         endcase
         if (phase != prev && phase == PH_DONE) bodies_done++;
         if (phase != prev && phase == PH_ERROR) bodies_bad++;
         r.body_done    = (phase == PH_DONE);
         r.format_error = (phase == PH_ERROR);
         decoded_beats.insert(decoded_beats.size(), r);
      endtask

      task check_beat(input rsp_beat_type got);
         rsp_beat_type want;
         if (decoded_beats.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing outstanding, byte %02h",
                                      got.out_byte));
            return;
         end
         want = decoded_beats.pop_front();
         checked++;
         if (got.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("beat %0d out_byte %02h, predicted %02h",
                                      checked, got.out_byte, want.out_byte));
         end
         if (got.out_valid !== want.out_valid) begin
            report_mismatch($sformatf("beat %0d out_valid %b, predicted %b",
                                      checked, got.out_valid, want.out_valid));
         end
         if (got.body_done !== want.body_done) begin
            report_mismatch($sformatf("beat %0d body_done %b, predicted %b",
                                      checked, got.body_done, want.body_done));
         end
         if (got.format_error !== want.format_error) begin
            report_mismatch($sformatf("beat %0d format_error %b, predicted %b",
                                      checked, got.format_error, want.format_error));
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block under test.
   // -------------------------------------------------------------------------
   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic [7:0] req_in_byte    = 8'h00;
   logic       req_start_body = 1'b0;
   logic       rsp_ready      = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_valid;
   logic       rsp_body_done;
   logic       rsp_format_error;

   always #10 clock = ~clock;

   chunked_body_decoder #(
      .SIZE_DIGITS (SIZE_DIGITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_start_body   (req_start_body),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_body_done    (rsp_body_done),
      .rsp_format_error (rsp_format_error)
   );

   chunk_decode_scoreboard sb;
   body_byte_type          stim_q[$];
   int                     cycle_count = 0;
   int                     hold_left   = 0;
   int                     burst_left  = 0;

   // Watchdog. A hang anywhere in the handshakes ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("chunked_body_decoder test failed");
         $finish;
      end
   end

   // The receiver steps through four stall styles in turn, set by cycle_count[10:9]:
   // always ready, coin flip, mostly stalled, and ready with long holds.
   always @(posedge clock) begin
      case (cycle_count[10:9])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2'd2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: begin
            if (hold_left != 0) begin
               hold_left <= hold_left - 1;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 5) == 0) begin
                  hold_left <= $urandom_range(1, 12);
               end
            end
         end
      endcase
   end

   // Both channels are sampled at the edge, before any register updates, so
   // each beat is seen exactly as the block saw it. The request beat is
   // noted first; its result can only come out at a later edge anyway.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_byte(req_in_byte, req_start_body);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_beat({rsp_out_byte, rsp_out_valid, rsp_body_done, rsp_format_error});
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus building.
   // -------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b);
      body_byte_type item;
      item.b = b;
      item.s = 1'b0;
      stim_q.insert(stim_q.size(), item);
   endtask

   // Appends a string; its first byte optionally carries the start mark.
   task automatic push_text(input string t, input logic first_start);
      int i;
      int base;
      base = stim_q.size();
      for (i = 0; i < t.len(); i++) begin
         push_byte(t[i]);
      end
      stim_q[base].s = first_start;
   endtask

   // Writes a size line's digits, with leading zeros and mixed case. Now and
   // then it writes exactly the allowed number of digits, or one too many.
   task automatic push_size(input logic [63:0] value);
      int          sig;
      int          ndig;
      int          roll;
      int          i;
      logic [3:0]  nib;
      sig = 1;
      while (sig < 16 && (value >> (4 * sig)) != 0) begin
         sig++;
      end
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         ndig = SIZE_DIGITS;
      end else if (roll < 14) begin
         ndig = SIZE_DIGITS + 1;
      end else begin
         ndig = sig + $urandom_range(0, 1);
         if (ndig > SIZE_DIGITS) ndig = SIZE_DIGITS;
      end
      if (ndig < sig) ndig = sig;
      for (i = ndig - 1; i >= 0; i--) begin
         nib = 4'(value >> (4 * i));
         if (nib < 4'd10) begin
            push_byte(8'h30 + {4'h0, nib});
         end else begin
            push_byte(($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, nib} - 8'd10);
         end
      end
   endtask

   // Builds one body: a few chunks, the zero chunk and the closing CRLF,
   // sometimes followed by stray bytes. About one body in five is broken in
   // one place, and one in twenty is plain noise.
   task automatic make_body();
      int            first;
      int            nchunks;
      int            k;
      int            n;
      int            pos;
      logic [63:0]   sz;
      bit            abandoned;
      flaw_kind_type flaw;
      first     = stim_q.size();
      abandoned = 1'b0;
      if ($urandom_range(0, 19) == 0) begin
         n = $urandom_range(1, 12);
         for (k = 0; k < n; k++) begin
            push_byte(8'($urandom));
            stim_q[stim_q.size() - 1].s = ($urandom_range(0, 3) == 0);
         end
         return;
      end
      flaw    = ($urandom_range(0, 4) == 0) ? flaw_kind_type'($urandom_range(1, 5))
                                            : FLAW_NONE;
      nchunks = $urandom_range(0, 4);
      for (k = 0; k < nchunks && !abandoned; k++) begin
         if ($urandom_range(0, 24) == 0) begin
            // A size near the top of the counter. Only a little of its data
            // follows; the next body's start mark cuts it short.
            sz        = {32'd0, 4'($urandom_range(1, 15)), 28'($urandom)};
            abandoned = 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            sz = 64'($urandom_range(17, 64));
         end else begin
            sz = 64'($urandom_range(1, 16));
         end
         push_size(sz);
         push_byte(CH_CR);
         push_byte(CH_LF);
         n = abandoned ? $urandom_range(1, 24) : int'(sz);
         repeat (n) begin
            // Payload carries CR and LF bytes now and then as plain data.
            case ($urandom_range(0, 9))
               0:       push_byte(CH_CR);
               1:       push_byte(CH_LF);
               default: push_byte(8'($urandom));
            endcase
         end
         if (!abandoned) begin
            push_byte(CH_CR);
            push_byte(CH_LF);
         end
      end
      if (!abandoned) begin
         push_size(64'd0);
         push_byte(CH_CR);
         push_byte(CH_LF);
         if (flaw == FLAW_TRAILER) begin
            push_text("T:1", 1'b0);
            push_byte(CH_CR);
            push_byte(CH_LF);
         end
         push_byte(CH_CR);
         push_byte(CH_LF);
         repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
      end
      // A body rarely arrives without its start mark.
      stim_q[first].s = ($urandom_range(0, 29) != 0);
      pos = $urandom_range(first, stim_q.size() - 1);
      case (flaw)
         FLAW_SWAP: begin
            case ($urandom_range(0, 5))
               0:       stim_q[pos].b = ";";
               1:       stim_q[pos].b = " ";
               2:       stim_q[pos].b = CH_CR;
               3:       stim_q[pos].b = CH_LF;
               4:       stim_q[pos].b = "g";
               default: stim_q[pos].b = 8'($urandom);
            endcase
         end
         FLAW_DROP:    stim_q.delete(pos);
         FLAW_RESTART: stim_q[pos].s = 1'b1;
         FLAW_CUT: begin
            if (pos == first) pos++;
            while (stim_q.size() > pos) stim_q.delete(stim_q.size() - 1);
         end
         default: begin
         end
      endcase
   endtask

   // -------------------------------------------------------------------------
   // Request driver. Beats go out in bursts of random length; between bursts
   // valid drops for a random gap. Once raised, valid and the byte hold until
   // the beat is taken.
   // -------------------------------------------------------------------------
   task automatic send_queue();
      body_byte_type item;
      int            gap;
      while (stim_q.size() != 0) begin
         item = stim_q.pop_front();
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
         end
         burst_left--;
         req_valid      <= 1'b1;
         req_in_byte    <= item.b;
         req_start_body <= item.s;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
      end
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed bodies. The first one comes with no start mark at all: the
      // parser must already sit at a size line after reset. It carries an
      // all-ones payload byte and one stray byte after body_done.
      push_text("1\015\012", 1'b0);
      push_byte(8'hFF);
      push_text("\015\0120\015\012\015\012z", 1'b0);
      // A trailer line after the zero chunk.
      push_text("0\015\012X", 1'b1);
      // A size line that is only a CR.
      push_text("\015", 1'b1);
      // A chunk extension mark, then a byte that lands after the error.
      push_text(";7", 1'b1);
      // One size digit beyond the limit.
      push_text("123456789", 1'b1);
      // The size line's CR is not followed by LF.
      push_text("1\015X", 1'b1);
      send_queue();

      while (sb.parsed_beats < PARSED_BEATS) begin
         make_body();
         send_queue();
      end
      req_valid <= 1'b0;

      // Drain: every noted byte owes exactly one result beat.
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d parsed bytes; %0d result beats checked, %0d of them payload.",
               sb.parsed_beats, sb.checked, sb.payload_beats);
      $display("Bodies completed: %0d, malformed bodies flagged: %0d, mismatches: %0d.",
               sb.bodies_done, sb.bodies_bad, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("chunked_body_decoder test passed");
      end else begin
         $display("chunked_body_decoder test failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/cbd_pkg.sv
rtl/core/cbd_parser.sv
rtl/core/cbd_out_reg.sv
rtl/core/chunked_body_decoder.sv
sim/tb_chunked_body_decoder.sv
